/* src/lldt_pkg.sv */
package lldt_pkg;

  localparam int unsigned LLDT_MAX_PORTS = 16;

  localparam logic [63:0] MAGIC_LO   = 64'h8cb5f3192996a86b;
  localparam logic [63:0] MAGIC_HI   = 64'h18c6659dc30d46f2;
  localparam logic [63:0] PEER_RESET = 64'h0000_0001_0000_0000;
  localparam logic [4:0]  COUNT_MAX  = 5'd31;

  typedef enum logic [1:0] {
    OP_SEND       = 2'd0,
    OP_CHECK      = 2'd1,
    OP_INVALIDATE = 2'd2,
    OP_QUERY      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_COMPLETE  = 3'd2,
    ST_BAD_MAGIC = 3'd3,
    ST_BAD_TYPE  = 3'd4
  } status_t;

  typedef enum logic [7:0] {
    REG_OWN_NODE     = 8'd0,
    REG_ACTIVE_PORTS = 8'd1,
    REG_ANNOUNCE     = 8'd2,
    REG_ACKNOWLEDGE  = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  port;
    logic [63:0] local_stamp;
    logic [63:0] rx_word0;
    logic [63:0] rx_word1;
    logic [63:0] rx_word2;
    logic [63:0] rx_word3;
    logic [63:0] rx_word4;
    logic [63:0] rx_word5;
  } in_item_t;

  typedef struct packed {
    logic [63:0] tx_word0;
    logic [63:0] tx_word1;
    logic [63:0] tx_word2;
    logic [63:0] tx_word3;
    logic [63:0] tx_word4;
    logic [63:0] tx_word5;
    logic [2:0]  status;
    logic [4:0]  incoming_known;
    logic [4:0]  outgoing_acked;
  } out_item_t;

  typedef struct packed {
    logic [31:0] own_node;
    logic [4:0]  active_ports;
    logic [31:0] announce_code;
    logic [31:0] acknowledge_code;
  } cfg_t;

  // peer words are kept in frame encoding: node low, port plus one high
  typedef struct packed {
    logic        in_v;
    logic        out_v;
    logic [63:0] in_delay;
    logic [63:0] in_peer;
    logic [63:0] out_delay;
    logic [63:0] out_peer;
    logic [4:0]  in_cnt;
    logic [4:0]  out_cnt;
  } edge_rd_t;

  typedef struct packed {
    logic        in_set;
    logic        out_set;
    logic [63:0] in_delay;
    logic [63:0] out_delay;
    logic [63:0] peer;
    logic [4:0]  in_cnt;
    logic [4:0]  out_cnt;
  } edge_wr_t;

endpackage

/* src/link_latency_discovery_table.sv */
// channel  | handshake                 | payload
// ---------+---------------------------+---------------------------------
// input    | start, busy               | in_item (in_item_t)
// result   | out_strobe, one cycle     | out_item (out_item_t)
// config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// One item per cycle; busy and cfg_ready stay low and high respectively.
// A start passes through the input register, then one pass of
// table read, subtract and write into the result register.
// rst_n is synchronous; it clears the edge valid bits and counters.
// The receiver cannot stall: each result is shown for exactly one cycle.
module link_latency_discovery_table
  import lldt_pkg::*;
#(
  parameter int unsigned MAX_PORTS = LLDT_MAX_PORTS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IDX_W = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;

  cfg_t      cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_strobe_r;
  out_item_t out_item_r;
  out_item_t res;
  edge_rd_t  rd;
  edge_wr_t  wr;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_node         <= '0;
      cfg_r.active_ports     <= 5'd16;
      cfg_r.announce_code    <= '0;
      cfg_r.acknowledge_code <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OWN_NODE:     cfg_r.own_node         <= cfg_data;
        REG_ACTIVE_PORTS: cfg_r.active_ports     <= cfg_data[4:0];
        REG_ANNOUNCE:     cfg_r.announce_code    <= cfg_data;
        REG_ACKNOWLEDGE:  cfg_r.acknowledge_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_valid_r   <= start && !busy;
      out_strobe_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_item_r <= in_item;
    end
    if (s1_valid_r) begin
      out_item_r <= res;
    end
  end

  lldt_edge_store #(
    .MAX_PORTS (MAX_PORTS),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .idx   (s1_item_r.port[IDX_W-1:0]),
    .wr    (wr),
    .rd    (rd)
  );

  lldt_core #(
    .MAX_PORTS (MAX_PORTS)
  ) u_core (
    .vld  (s1_valid_r),
    .item (s1_item_r),
    .cfg  (cfg_r),
    .rd   (rd),
    .res  (res),
    .wr   (wr)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> out_strobe)
    else $error("item in flight produced no result");

  a_in_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(out_strobe) |->
      out_item.incoming_known >= $past(out_item.incoming_known))
    else $error("incoming edge count went down");

  a_out_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(out_strobe) |->
      out_item.outgoing_acked >= $past(out_item.outgoing_acked))
    else $error("outgoing edge count went down");

  a_range_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && res.status == ST_RANGE |-> !wr.in_set && !wr.out_set)
    else $error("edge written for an out of range port");
`endif

endmodule

/* src/lldt_edge_store.sv */
module lldt_edge_store
  import lldt_pkg::*;
#(
  parameter int unsigned MAX_PORTS = LLDT_MAX_PORTS,
  parameter int unsigned IDX_W     = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] idx,
  input  edge_wr_t         wr,
  output edge_rd_t         rd
);

  logic [MAX_PORTS-1:0] in_valid_r;
  logic [MAX_PORTS-1:0] out_valid_r;
  logic [63:0]          in_delay_r  [MAX_PORTS];
  logic [63:0]          in_peer_r   [MAX_PORTS];
  logic [63:0]          out_delay_r [MAX_PORTS];
  logic [63:0]          out_peer_r  [MAX_PORTS];
  logic [4:0]           in_cnt_r;
  logic [4:0]           out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= '0;
      out_valid_r <= '0;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
    end else begin
      if (wr.in_set) begin
        in_valid_r[idx] <= 1'b1;
      end
      if (wr.out_set) begin
        out_valid_r[idx] <= 1'b1;
      end
      in_cnt_r  <= wr.in_cnt;
      out_cnt_r <= wr.out_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.in_set) begin
      in_delay_r[idx] <= wr.in_delay;
      in_peer_r[idx]  <= wr.peer;
    end
    if (wr.out_set) begin
      out_delay_r[idx] <= wr.out_delay;
      out_peer_r[idx]  <= wr.peer;
    end
  end

  // entries not yet valid read as their reset value
  always_comb begin
    rd.in_v      = in_valid_r[idx];
    rd.out_v     = out_valid_r[idx];
    rd.in_delay  = rd.in_v  ? in_delay_r[idx]  : '0;
    rd.in_peer   = rd.in_v  ? in_peer_r[idx]   : PEER_RESET;
    rd.out_delay = rd.out_v ? out_delay_r[idx] : '0;
    rd.out_peer  = rd.out_v ? out_peer_r[idx]  : PEER_RESET;
    rd.in_cnt    = in_cnt_r;
    rd.out_cnt   = out_cnt_r;
  end

endmodule

/* src/lldt_core.sv */
module lldt_core
  import lldt_pkg::*;
#(
  parameter int unsigned MAX_PORTS = LLDT_MAX_PORTS
) (
  input  logic      vld,
  input  in_item_t  item,
  input  cfg_t      cfg,
  input  edge_rd_t  rd,
  output out_item_t res,
  output edge_wr_t  wr
);

  localparam logic [7:0] PORT_LIM = 8'(MAX_PORTS);

  logic        in_range;
  logic        magic_ok;
  logic        is_ann;
  logic        is_ack;
  logic [31:0] port_enc;

  always_comb begin
    in_range = (item.port < {3'b000, cfg.active_ports}) && (item.port < PORT_LIM);
    magic_ok = (item.rx_word0 == MAGIC_LO) && (item.rx_word1 == MAGIC_HI);
    is_ann   = item.rx_word2 == {32'h0, cfg.announce_code};
    is_ack   = item.rx_word2 == {32'h0, cfg.acknowledge_code};
    port_enc = {24'h0, item.port} + 32'd1;

    res = '0;
    res.status = ST_OK;

    wr           = '0;
    wr.in_delay  = item.local_stamp - item.rx_word3;
    wr.out_delay = item.rx_word3 - item.rx_word4;
    wr.peer      = item.rx_word5;

    if (!in_range) begin
      res.status = ST_RANGE;
    end else begin
      unique case (op_t'(item.op))
        OP_SEND: begin
          res.tx_word0 = MAGIC_LO;
          res.tx_word1 = MAGIC_HI;
          res.tx_word2 = {32'h0, rd.in_v ? cfg.acknowledge_code : cfg.announce_code};
          res.tx_word3 = item.local_stamp;
          res.tx_word4 = rd.in_v ? item.local_stamp - rd.in_delay : '0;
          res.tx_word5 = {port_enc, cfg.own_node};
        end
        OP_CHECK: begin
          priority if (rd.in_v && rd.out_v) begin
            res.status = ST_COMPLETE;
          end else if (!magic_ok) begin
            res.status = ST_BAD_MAGIC;
          end else if (is_ann) begin
            wr.in_set = vld && !rd.in_v;
          end else if (is_ack) begin
            wr.out_set = vld && !rd.out_v;
          end else begin
            res.status = ST_BAD_TYPE;
          end
        end
        OP_INVALIDATE: begin
          res.status = ST_OK;
        end
        OP_QUERY: begin
          res.tx_word0 = rd.in_delay;
          res.tx_word1 = rd.in_peer;
          res.tx_word2 = rd.out_delay;
          res.tx_word3 = rd.out_peer;
          res.tx_word4 = {62'h0, rd.out_v, rd.in_v};
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end

    wr.in_cnt  = (wr.in_set && rd.in_cnt != COUNT_MAX) ? rd.in_cnt + 5'd1 : rd.in_cnt;
    wr.out_cnt = (wr.out_set && rd.out_cnt != COUNT_MAX) ? rd.out_cnt + 5'd1 : rd.out_cnt;
    res.incoming_known = wr.in_cnt;
    res.outgoing_acked = wr.out_cnt;
  end

endmodule

/* sim/link_latency_discovery_table_tb.sv */
module link_latency_discovery_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lldt_pkg::*;

  localparam int WATCHDOG_LIMIT = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [7:0] REG_UNUSED = 8'd200;
  localparam logic [63:0] T_A = 64'h0123_4567_89ab_cdef;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_strobe;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor state; peers kept in frame encoding
  logic        tbl_in_v    [LLDT_MAX_PORTS];
  logic [63:0] tbl_in_delay[LLDT_MAX_PORTS];
  logic [63:0] tbl_in_peer [LLDT_MAX_PORTS];
  logic        tbl_out_v    [LLDT_MAX_PORTS];
  logic [63:0] tbl_out_delay[LLDT_MAX_PORTS];
  logic [63:0] tbl_out_peer [LLDT_MAX_PORTS];
  logic [4:0]  cnt_in;
  logic [4:0]  cnt_out;

  logic [31:0] cfg_own = 32'd0;
  logic [4:0]  cfg_active = 5'd16;
  logic [31:0] cfg_ann = 32'd0;
  logic [31:0] cfg_ack = 32'd1;

  out_item_t pending_results[$];
  dir_row_t  dir_rows[$];
  string     field_names[9] = '{"tx_word0", "tx_word1", "tx_word2", "tx_word3", "tx_word4",
                                "tx_word5", "status", "incoming_known", "outgoing_acked"};

  int mismatch_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int config_sets = 0;
  int stall_cycles = 0;
  int no_idle_left = 0;
  int status_seen[5] = '{default: 0};

  link_latency_discovery_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t mk_item(op_t op, logic [7:0] port, logic [63:0] t,
                                       logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                                       logic [63:0] w3, logic [63:0] w4, logic [63:0] w5);
    in_item_t it;
    it = '{op, port, t, w0, w1, w2, w3, w4, w5};
    return it;
  endfunction

  function automatic in_item_t mk_frame(logic [7:0] port, logic [63:0] t, logic [63:0] typ,
                                        logic [63:0] w3, logic [63:0] w4, logic [63:0] w5);
    return mk_item(OP_CHECK, port, t, MAGIC_LO, MAGIC_HI, typ, w3, w4, w5);
  endfunction

  function automatic in_item_t rand_item(op_t op, logic [7:0] port);
    return mk_item(op, port, rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                   rand64());
  endfunction

  function automatic out_item_t blank_res(status_t st, logic [4:0] ki, logic [4:0] ko);
    out_item_t r;
    r = '0;
    r.status = st;
    r.incoming_known = ki;
    r.outgoing_acked = ko;
    return r;
  endfunction

  function automatic logic [7:0] pick_port();
    int lim;
    lim = (cfg_active < 16) ? int'(cfg_active) : 16;
    if (lim == 0 || $urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, lim - 1));
  endfunction

  function automatic out_item_t predict_discovery(in_item_t it);
    out_item_t   r;
    logic [3:0]  p;
    logic [63:0] t;
    logic [31:0] pp;
    r = '0;
    p = it.port[3:0];
    t = it.local_stamp;
    pp = 32'(it.port) + 32'd1;
    if (it.port >= cfg_active || it.port >= LLDT_MAX_PORTS) begin
      r.status = ST_RANGE;
    end else begin
      case (op_t'(it.op))
        OP_SEND: begin
          r.tx_word0 = MAGIC_LO;
          r.tx_word1 = MAGIC_HI;
          r.tx_word2 = tbl_in_v[p] ? {32'h0, cfg_ack} : {32'h0, cfg_ann};
          r.tx_word3 = t;
          r.tx_word4 = tbl_in_v[p] ? t - tbl_in_delay[p] : 64'd0;
          r.tx_word5 = {pp, cfg_own};
        end
        OP_CHECK: begin
          if (tbl_in_v[p] && tbl_out_v[p]) begin
            r.status = ST_COMPLETE;
          end else if (it.rx_word0 != MAGIC_LO || it.rx_word1 != MAGIC_HI) begin
            r.status = ST_BAD_MAGIC;
          end else if (it.rx_word2 == {32'h0, cfg_ann}) begin
            if (!tbl_in_v[p]) begin
              tbl_in_v[p] = 1'b1;
              tbl_in_delay[p] = t - it.rx_word3;
              tbl_in_peer[p] = it.rx_word5;
              if (cnt_in < COUNT_MAX) cnt_in = cnt_in + 5'd1;
            end
          end else if (it.rx_word2 == {32'h0, cfg_ack}) begin
            if (!tbl_out_v[p]) begin
              tbl_out_v[p] = 1'b1;
              tbl_out_delay[p] = it.rx_word3 - it.rx_word4;
              tbl_out_peer[p] = it.rx_word5;
              if (cnt_out < COUNT_MAX) cnt_out = cnt_out + 5'd1;
            end
          end else begin
            r.status = ST_BAD_TYPE;
          end
        end
        OP_QUERY: begin
          r.tx_word0 = tbl_in_delay[p];
          r.tx_word1 = tbl_in_peer[p];
          r.tx_word2 = tbl_out_delay[p];
          r.tx_word3 = tbl_out_peer[p];
          r.tx_word4 = {62'd0, tbl_out_v[p], tbl_in_v[p]};
        end
        default: ;
      endcase
    end
    r.incoming_known = cnt_in;
    r.outgoing_acked = cnt_out;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic check_result(out_item_t exp, out_item_t act);
    logic [63:0] e[9];
    logic [63:0] a[9];
    e = '{exp.tx_word0, exp.tx_word1, exp.tx_word2, exp.tx_word3, exp.tx_word4, exp.tx_word5,
          64'(exp.status), 64'(exp.incoming_known), 64'(exp.outgoing_acked)};
    a = '{act.tx_word0, act.tx_word1, act.tx_word2, act.tx_word3, act.tx_word4, act.tx_word5,
          64'(act.status), 64'(act.incoming_known), 64'(act.outgoing_acked)};
    for (int i = 0; i < 9; i++) begin
      if (e[i] !== a[i])
        note_mismatch($sformatf("%s expected %h got %h", field_names[i], e[i], a[i]));
    end
  endtask

  task automatic run_item(in_item_t it, logic typed, out_item_t typed_res);
    int        gap;
    out_item_t pred;
    if (no_idle_left > 0) begin
      no_idle_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 7) == 0) no_idle_left = $urandom_range(5, 30);
      gap = $urandom_range(0, 4);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pred = predict_discovery(it);
    pending_results.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic configure(logic [31:0] own, logic [31:0] act, logic [31:0] ann,
                           logic [31:0] ack, bit poke_unused);
    logic [7:0]  idx[5];
    logic [31:0] dat[5];
    int          n;
    idx = '{REG_OWN_NODE, REG_ACTIVE_PORTS, REG_ANNOUNCE, REG_ACKNOWLEDGE, REG_UNUSED};
    dat = '{own, act, ann, ack, $urandom};
    n = poke_unused ? 5 : 4;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= dat[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_OWN_NODE:     cfg_own = dat[i];
        REG_ACTIVE_PORTS: cfg_active = dat[i][4:0];
        REG_ANNOUNCE:     cfg_ann = dat[i];
        REG_ACKNOWLEDGE:  cfg_ack = dat[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    config_sets++;
  endtask

  task automatic run_random(int n);
    int         done;
    int         s;
    logic [7:0] p;
    in_item_t   it;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 9) < 7) begin
        // send / announce / send / acknowledge / query on one port
        p = pick_port();
        for (s = 0; s < 5; s++) begin
          if ($urandom_range(0, 4) != 0) begin
            case (s)
              1: it = mk_frame(p, rand64(), {32'h0, cfg_ann}, rand64(), rand64(), rand64());
              3: it = mk_frame(p, rand64(), {32'h0, cfg_ack}, rand64(), rand64(), rand64());
              4: it = rand_item(OP_QUERY, p);
              default: it = rand_item(OP_SEND, p);
            endcase
            run_item(it, 1'b0, '0);
            done++;
          end
        end
      end else begin
        it = rand_item(op_t'($urandom_range(0, 3)),
                       $urandom_range(0, 1) ? pick_port() : 8'($urandom_range(0, 255)));
        case ($urandom_range(0, 2))
          0: begin
            it.rx_word0 = MAGIC_LO;
            it.rx_word1 = MAGIC_HI;
            if ($urandom_range(0, 1)) it.rx_word2 = {32'h0, $urandom};
          end
          1: begin
            it.rx_word0 = MAGIC_LO;
            it.rx_word1 = MAGIC_HI;
            if ($urandom_range(0, 1)) it.rx_word0[$urandom_range(0, 63)] ^= 1'b1;
            else it.rx_word1[$urandom_range(0, 63)] ^= 1'b1;
          end
          default: ;
        endcase
        run_item(it, 1'b0, '0);
        done++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (out_item.status < 5) status_seen[out_item.status]++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result %h", out_item));
      end else begin
        check_result(pending_results.pop_front(), out_item);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [31:0] code;
    for (int i = 0; i < LLDT_MAX_PORTS; i++) begin
      tbl_in_v[i] = 1'b0;
      tbl_in_delay[i] = '0;
      tbl_in_peer[i] = PEER_RESET;
      tbl_out_v[i] = 1'b0;
      tbl_out_delay[i] = '0;
      tbl_out_peer[i] = PEER_RESET;
    end
    cnt_in = '0;
    cnt_out = '0;

    // reset values, range limits and error codes first
    dir_rows.push_back('{rand_item(OP_QUERY, 8'd0), 1'b1,
                         out_item_t'{64'd0, PEER_RESET, 64'd0, PEER_RESET, 64'd0, 64'd0,
                                     ST_OK, 5'd0, 5'd0}});
    dir_rows.push_back('{mk_item(OP_SEND, 8'd0, T_A, '0, '0, '0, '0, '0, '0), 1'b1,
                         out_item_t'{MAGIC_LO, MAGIC_HI, 64'd0, T_A, 64'd0,
                                     64'h0000_0001_0000_0000, ST_OK, 5'd0, 5'd0}});
    dir_rows.push_back('{mk_item(OP_INVALIDATE, 8'd15, '1, '1, '1, '1, '1, '1, '1), 1'b1,
                         blank_res(ST_OK, 5'd0, 5'd0)});
    dir_rows.push_back('{mk_frame(8'd16, T_A, 64'd0, 64'd1, 64'd2, 64'd3), 1'b1,
                         blank_res(ST_RANGE, 5'd0, 5'd0)});
    dir_rows.push_back('{mk_item(OP_SEND, 8'd255, '1, '0, '0, '0, '0, '0, '0), 1'b1,
                         blank_res(ST_RANGE, 5'd0, 5'd0)});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd3, T_A, MAGIC_LO ^ 64'd1, MAGIC_HI, '0, '0, '0,
                                 '0), 1'b1, blank_res(ST_BAD_MAGIC, 5'd0, 5'd0)});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd3, T_A, MAGIC_LO, MAGIC_HI ^ {1'b1, 63'd0}, '0,
                                 '0, '0, '0), 1'b1, blank_res(ST_BAD_MAGIC, 5'd0, 5'd0)});
    dir_rows.push_back('{mk_frame(8'd3, T_A, 64'd5, '0, '0, '0), 1'b1,
                         blank_res(ST_BAD_TYPE, 5'd0, 5'd0)});
    dir_rows.push_back('{mk_frame(8'd3, T_A, 64'h1_0000_0000, '0, '0, '0), 1'b1,
                         blank_res(ST_BAD_TYPE, 5'd0, 5'd0)});
    dir_rows.push_back('{mk_frame(8'd3, T_A, 64'h1_0000_0001, '0, '0, '0), 1'b1,
                         blank_res(ST_BAD_TYPE, 5'd0, 5'd0)});
    // announce with a delay that wraps, then a repeat that must not overwrite
    dir_rows.push_back('{mk_frame(8'd3, 64'd3, 64'd0, 64'd5, '0, 64'h0000_0008_0000_00aa),
                         1'b0, '0});
    dir_rows.push_back('{mk_frame(8'd3, T_A, 64'd0, 64'd7, '1, 64'h0000_0002_0000_0001),
                         1'b0, '0});
    dir_rows.push_back('{rand_item(OP_SEND, 8'd3), 1'b0, '0});
    dir_rows.push_back('{mk_frame(8'd3, T_A, 64'd1, 64'd0, '1, 64'h0000_0010_dead_beef),
                         1'b0, '0});
    dir_rows.push_back('{mk_frame(8'd3, T_A, 64'd0, '0, '0, '0), 1'b1,
                         blank_res(ST_COMPLETE, 5'd1, 5'd1)});
    dir_rows.push_back('{rand_item(OP_QUERY, 8'd3), 1'b0, '0});
    // peer port field at both wrap points
    dir_rows.push_back('{mk_frame(8'd15, '1, 64'd0, 64'd0, '0, '1), 1'b0, '0});
    dir_rows.push_back('{mk_frame(8'd15, '0, 64'd1, '1, 64'd0, 64'd0), 1'b0, '0});
    dir_rows.push_back('{rand_item(OP_QUERY, 8'd15), 1'b0, '0});
    // acknowledge before any announce: outgoing edge only
    dir_rows.push_back('{mk_frame(8'd0, T_A, 64'd1, T_A, 64'd9, 64'h0000_0005_0000_0007),
                         1'b0, '0});
    dir_rows.push_back('{rand_item(OP_SEND, 8'd0), 1'b0, '0});
    dir_rows.push_back('{rand_item(OP_QUERY, 8'd0), 1'b0, '0});
    dir_rows.push_back('{rand_item(OP_INVALIDATE, 8'd0), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) run_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    drain();
    configure(32'hFFFF_FFFF, 32'd2, 32'd5, 32'hFFFF_FFFF, 1'b0);
    run_random(150);
    drain();
    configure($urandom, 32'd0, $urandom, $urandom, 1'b0);
    run_random(60);
    drain();
    code = $urandom;
    configure($urandom, 32'd5, code, code, 1'b0);
    run_random(200);
    drain();
    configure($urandom, 32'd9, 32'd0, 32'hFFFF_FFFF, 1'b0);
    run_random(250);
    drain();
    configure($urandom, 32'hFFFF_FFFF, $urandom, $urandom, 1'b0);
    run_random(400);
    drain();
    configure(32'd0, 32'd16, 32'd0, 32'd1, 1'b1);
    run_random(390);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("%0d transactions (%0d directed), %0d results checked, %0d register settings",
             items_sent, dir_rows.size(), results_checked, config_sets);
    $display("status seen: ok %0d, range %0d, complete %0d, magic %0d, type %0d, mismatches %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
src/lldt_pkg.sv
src/lldt_edge_store.sv
src/lldt_core.sv
src/link_latency_discovery_table.sv
sim/link_latency_discovery_table_tb.sv
